// File: src/sfa_pkg.sv
// Shared types and constants for the slab flag allocator.
// No dependencies; imported by slab_flag_allocator_top.
package sfa_pkg;

  localparam int ADDR_BITS       = 48;
  localparam int CFG_DATA_W      = 48;
  localparam int CFG_IDX_W       = 2;
  localparam int FREE_OUT_W      = 7;
  localparam int FREE_OUT_MAX    = 127;
  localparam int MAX_SLABS_DEF   = 64;
  localparam int ROW_BITS        = 8;
  localparam int ROW_LOG2        = 3;
  localparam int LOG2_W          = 6;

  localparam logic [LOG2_W-1:0] SLAB_LOG2_RESET = 6'd32;
  localparam logic [LOG2_W-1:0] SLAB_LOG2_MIN   = 6'd12;
  localparam logic [LOG2_W-1:0] SLAB_LOG2_MAX   = 6'd40;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK           = 2'd0,
    STS_NONE_FREE    = 2'd1,
    STS_NOT_ALLOC    = 2'd2,
    STS_OUT_OF_RANGE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE      = 2'd0,
    CFG_REGION    = 2'd1,
    CFG_SLAB_LOG2 = 2'd2,
    CFG_ENABLE    = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_ALLOC_ADDR,
    S_FREE_IDX,
    S_FREE_RD,
    S_FREE_CHK,
    S_CHECK,
    S_RESP
  } state_t;

endpackage

// File: src/slab_flag_allocator_top.sv
// Slab flag allocator: first-fit slab allocation over a used-flag bitmap.
// Depends on sfa_pkg (types, register indexes, constants).
// Throughput: one item at a time; the next beat is taken back in S_IDLE once
//   the result is registered and no free-count reload is pending. The flag RAM port
//   (one row read or written per cycle) sets the allocate scan time.
// Reset (rst_n low, synchronous) and writes to base, region or slab size invalidate all
//   flag rows at once and have the free count reloaded in S_IDLE; no clearing pass.
module slab_flag_allocator_top #(
  parameter int MAX_SLABS = sfa_pkg::MAX_SLABS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfa_pkg::CFG_DATA_W-1:0]   cfg_data,
  // request stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [47:0]                      in_tdata,   // [47:0] address
  input  logic [1:0]                       in_tuser,   // [1:0] operation
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [55:0]                      out_tdata,  // [47:0] slab_address,
                                                       // [54:48] free_slabs, [55] in_region
  output logic [1:0]                       out_tuser   // [1:0] status
);
  import sfa_pkg::*;

  localparam int NROWS = (MAX_SLABS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int CNT_W = $clog2(MAX_SLABS + 1);
  localparam int EXT_W = ROW_W + ROW_LOG2 + 1;  // slab index plus one spare bit

  // config registers
  logic [ADDR_BITS-1:0] base_r, region_r;
  logic [LOG2_W-1:0]    log2_r;
  logic                 en_r;
  logic                 reload_r, reload_nxt;

  // sequencer state
  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [ADDR_BITS-1:0] diff_r, diff_nxt;
  logic                 lt_base_r, lt_base_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     free_count_r, free_count_nxt;
  logic [ROW_W-1:0]     row_ptr_r, row_ptr_nxt;
  logic [ROW_LOG2-1:0]  bit_r, bit_nxt;

  // pending result
  logic [ADDR_BITS-1:0] res_addr_r, res_addr_nxt;
  status_t              res_status_r, res_status_nxt;
  logic                 res_inreg_r, res_inreg_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [ADDR_BITS-1:0]  out_addr_r, out_addr_nxt;
  logic [FREE_OUT_W-1:0] out_free_r, out_free_nxt;
  logic                  out_inreg_r, out_inreg_nxt;
  status_t               out_status_r, out_status_nxt;

  // flag RAM: one row of ROW_BITS flags per word, per-row valid bits
  logic [ROW_BITS-1:0] flag_mem [NROWS];
  logic [NROWS-1:0]    row_vld_r;
  logic [ROW_BITS-1:0] mem_q_r;
  logic                vld_q_r;
  logic                mem_we;
  logic [ROW_BITS-1:0] mem_wdata;
  logic [ROW_BITS-1:0] row_data;

  // shared datapath: one adder/subtractor and one right shifter
  logic [ADDR_BITS-1:0] alu_a, alu_b;
  logic                 alu_sub;
  logic [ADDR_BITS:0]   alu_sum;
  logic [ADDR_BITS-1:0] sh_in, sh_out;
  logic [LOG2_W-1:0]    eff_lg;
  logic [CNT_W-1:0]     cnt_calc;
  logic [ADDR_BITS-1:0] slab_off;

  // first-free search within the current row
  logic [ROW_BITS-1:0]  cand;
  logic                 hit;
  logic [ROW_LOG2-1:0]  hit_bit;
  logic                 last_row;
  logic [EXT_W-1:0]     cnt_ext, next_start;

  logic cfg_we, region_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  // base, region and slab-size writes restart the region
  assign region_we = cfg_we && (cfg_idx_t'(cfg_index) != CFG_ENABLE);

  // slab size clamped to the supported range
  always_comb begin
    if (log2_r < SLAB_LOG2_MIN) begin
      eff_lg = SLAB_LOG2_MIN;
    end else if (log2_r > SLAB_LOG2_MAX) begin
      eff_lg = SLAB_LOG2_MAX;
    end else begin
      eff_lg = log2_r;
    end
  end

  assign alu_sum  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                  + (ADDR_BITS+1)'(alu_sub);
  assign sh_in    = (state_r == S_FREE_IDX) ? diff_r : region_r;
  assign sh_out   = sh_in >> eff_lg;
  assign cnt_calc = (sh_out >= ADDR_BITS'(MAX_SLABS)) ? CNT_W'(MAX_SLABS) : CNT_W'(sh_out);
  assign slab_off = ADDR_BITS'({row_ptr_r, bit_r}) << eff_lg;

  assign row_data = vld_q_r ? mem_q_r : '0;

  assign cnt_ext    = EXT_W'(cnt_r);
  // first slab index of the next row
  assign next_start = {1'b0, row_ptr_r, ROW_LOG2'(0)} + EXT_W'(ROW_BITS);
  assign last_row   = (next_start >= cnt_ext);

  // free slabs in this row that also lie below the slab count
  always_comb begin
    for (int b = 0; b < ROW_BITS; b++) begin
      cand[b] = !row_data[b] && (EXT_W'({row_ptr_r, ROW_LOG2'(b)}) < cnt_ext);
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit     = 1'b1;
        hit_bit = ROW_LOG2'(b);
      end
    end
  end

  // sequencer: next state, datapath steering and result capture
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    diff_nxt       = diff_r;
    lt_base_nxt    = lt_base_r;
    cnt_nxt        = cnt_r;
    row_ptr_nxt    = row_ptr_r;
    bit_nxt        = bit_r;
    free_count_nxt = free_count_r;
    reload_nxt     = reload_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    res_inreg_nxt  = res_inreg_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_addr_nxt   = out_addr_r;
    out_free_nxt   = out_free_r;
    out_inreg_nxt  = out_inreg_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_wdata      = row_data;
    alu_a          = addr_r;
    alu_b          = base_r;
    alu_sub        = 1'b1;
    in_tready      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = !reload_r;
        if (reload_r) begin
          free_count_nxt = cnt_calc;
          reload_nxt     = 1'b0;
        end else if (in_tvalid) begin
          op_nxt    = op_t'(in_tuser);
          addr_nxt  = in_tdata;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        // addr - base, slab count from region size
        diff_nxt       = alu_sum[ADDR_BITS-1:0];
        lt_base_nxt    = !alu_sum[ADDR_BITS];
        cnt_nxt        = cnt_calc;
        row_ptr_nxt    = '0;
        res_addr_nxt   = '0;
        res_status_nxt = STS_OK;
        res_inreg_nxt  = 1'b0;
        unique case (op_r)
          OP_ALLOC: begin
            if (free_count_r == '0) begin
              res_status_nxt = STS_NONE_FREE;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          OP_FREE:  state_nxt = S_FREE_IDX;
          OP_CHECK: state_nxt = S_CHECK;
          OP_NONE:  state_nxt = S_RESP;
        endcase
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (hit) begin
          bit_nxt        = hit_bit;
          mem_we         = 1'b1;
          mem_wdata      = row_data | (ROW_BITS'(1) << hit_bit);
          free_count_nxt = free_count_r - CNT_W'(1);
          state_nxt      = S_ALLOC_ADDR;
        end else if (last_row) begin
          res_status_nxt = STS_NONE_FREE;
          state_nxt      = S_RESP;
        end else begin
          row_ptr_nxt = row_ptr_r + ROW_W'(1);
          state_nxt   = S_SCAN_RD;
        end
      end
      S_ALLOC_ADDR: begin
        alu_a        = base_r;
        alu_b        = slab_off;
        alu_sub      = 1'b0;
        res_addr_nxt = alu_sum[ADDR_BITS-1:0];
        state_nxt    = S_RESP;
      end
      S_FREE_IDX: begin
        if (lt_base_r || (sh_out >= ADDR_BITS'(cnt_r))) begin
          res_status_nxt = STS_OUT_OF_RANGE;
          state_nxt      = S_RESP;
        end else begin
          row_ptr_nxt = ROW_W'(sh_out >> ROW_LOG2);
          bit_nxt     = sh_out[ROW_LOG2-1:0];
          state_nxt   = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        state_nxt = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (!row_data[bit_r]) begin
          res_status_nxt = STS_NOT_ALLOC;
        end else begin
          mem_we         = 1'b1;
          mem_wdata      = row_data & ~(ROW_BITS'(1) << bit_r);
          free_count_nxt = free_count_r + CNT_W'(1);
        end
        state_nxt = S_RESP;
      end
      S_CHECK: begin
        // (addr - base) < region_bytes
        alu_a         = diff_r;
        alu_b         = region_r;
        res_inreg_nxt = en_r & !lt_base_r & !alu_sum[ADDR_BITS];
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          out_inreg_nxt  = res_inreg_r;
          out_free_nxt   = (32'(free_count_r) > 32'(FREE_OUT_MAX)) ?
                           FREE_OUT_W'(FREE_OUT_MAX) : FREE_OUT_W'(free_count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      free_count_r <= '0;
      reload_r     <= 1'b1;
      row_vld_r    <= '0;
      base_r       <= '0;
      region_r     <= '0;
      log2_r       <= SLAB_LOG2_RESET;
      en_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      free_count_r <= free_count_nxt;
      reload_r     <= reload_nxt | region_we;
      if (region_we) begin
        row_vld_r <= '0;
      end else if (mem_we) begin
        row_vld_r[row_ptr_r] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_BASE:      base_r   <= cfg_data[ADDR_BITS-1:0];
          CFG_REGION:    region_r <= cfg_data[ADDR_BITS-1:0];
          CFG_SLAB_LOG2: log2_r   <= cfg_data[LOG2_W-1:0];
          CFG_ENABLE:    en_r     <= cfg_data[0];
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    diff_r       <= diff_nxt;
    lt_base_r    <= lt_base_nxt;
    cnt_r        <= cnt_nxt;
    row_ptr_r    <= row_ptr_nxt;
    bit_r        <= bit_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    res_inreg_r  <= res_inreg_nxt;
    out_addr_r   <= out_addr_nxt;
    out_free_r   <= out_free_nxt;
    out_inreg_r  <= out_inreg_nxt;
    out_status_r <= out_status_nxt;
  end

  // flag RAM, registered read at the row pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      flag_mem[row_ptr_r] <= mem_wdata;
    end
    mem_q_r <= flag_mem[row_ptr_r];
    vld_q_r <= row_vld_r[row_ptr_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_inreg_r, out_free_r, out_addr_r};
  assign out_tuser  = out_status_r;

endmodule
